/* rtl/core/csnr_pkg.sv */
// Shared types and constants for the chroma share smoother.
// No dependencies.
`timescale 1ns / 1ps
package csnr_pkg;
  localparam int unsigned ShareW = 16;
  localparam int unsigned PcW = 4;
  localparam int unsigned CfgW = 7;
  localparam logic [ShareW-1:0] ShareOne = 16'hFFFF;
  localparam logic [CfgW-1:0] SmoothReset = 7'd9;

  typedef enum logic [6:0] {
    ST_FILL   = 7'b0000001,
    ST_RANK   = 7'b0000010,
    ST_EMIT   = 7'b0000100,
    ST_MEAN   = 7'b0001000,
    ST_DIVIDE = 7'b0010000,
    ST_NORM   = 7'b0100000,
    ST_WRITE  = 7'b1000000
  } state_t;
endpackage

/* rtl/core/csnr_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
module csnr_div #(
  parameter int unsigned NumW = 40,
  parameter int unsigned DenW = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            done,
  output logic [NumW-1:0] quo
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] q;
  logic [DenW:0] rem;
  logic [DenW-1:0] d;
  logic [CntW-1:0] cnt;
  logic busy;
  logic [DenW:0] trial;

  assign trial = {rem[DenW-1:0], q[NumW-1]};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q <= num;
        d <= den;
        rem <= '0;
        cnt <= CntW'(NumW);
      end else if (busy) begin
        if (trial >= {1'b0, d}) begin
          rem <= trial - {1'b0, d};
          q <= {q[NumW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q <= {q[NumW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* rtl/core/chroma_smooth_normalize_rank_core.sv */
// Top level of the chroma share smoother with ranked readout.
// Depends on csnr_pkg and csnr_div.
`timescale 1ns / 1ps
// One energy beat per pitch class is written into the frame memory, one beat per cycle. The beat
// that completes a frame starts a pass: each class is ranked by a sweep of the share memory,
// the ranked result beats are offered one at a time, each only after the last was taken, then
// each running mean is formed through a serial divider and each share renormalized through
// the same divider. During the pass and any output stall no energy beat and no configuration
// write is taken. Shares live in a single-port-read synchronous memory; after reset or
// restart a per-entry valid bit makes unwritten shares read as one over CLASSES.
module chroma_smooth_normalize_rank_core #(
  parameter int unsigned CLASSES = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] energy,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  pitch_class,
  output logic [15:0] share,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);
  localparam int unsigned IW = (CLASSES > 1) ? $clog2(CLASSES) : 1;
  localparam int unsigned JW = $clog2(CLASSES + 1);
  localparam int unsigned SumW = 16 + $clog2(CLASSES + 1);
  localparam int unsigned NumW = SumW + 16;
  localparam logic [15:0] Uniform = 16'(32'd65535 / CLASSES);

  csnr_pkg::state_t state;
  logic [15:0] share_mem [CLASSES];
  logic [15:0] energy_mem [CLASSES];
  logic [15:0] mean_mem [CLASSES];
  logic [CLASSES-1:0] sh_valid;
  logic [IW-1:0] pos, idx;
  logic [JW-1:0] j;
  logic [IW-1:0] rd_addr;
  logic [15:0] sh_q, en_q, mn_q;
  logic sh_v_q;
  logic [15:0] sh_rd, cur;
  logic [IW-1:0] j_q;
  logic rd_ok;
  logic [3:0] rank;
  logic hit;
  logic [3:0] rank_new;
  logic [6:0] smooth;
  logic [6:0] n;
  logic [SumW-1:0] sum;
  logic [15:0] rank_tab [CLASSES];
  logic [IW-1:0] emit_i;
  logic div_start, div_done;
  logic [NumW-1:0] div_num, div_quo;
  logic [SumW-1:0] div_den;
  logic [1:0] ph;
  logic [15:0] res_share;
  logic [3:0] res_pc;
  logic res_last;

  assign cfg_ready = (state == csnr_pkg::ST_FILL);
  assign in_stall = (state != csnr_pkg::ST_FILL);
  assign sh_rd = sh_v_q ? sh_q : Uniform;
  assign n = (smooth == 7'd0) ? 7'd1 : ((smooth > 7'd64) ? 7'd64 : smooth);
  assign hit = rd_ok && (sh_rd > cur || (sh_rd == cur && j_q < idx));
  assign rank_new = rank + {3'd0, hit};
  assign pitch_class = res_pc;
  assign share = res_share;
  assign last = res_last;

  always_ff @(posedge clk) begin
    sh_q <= share_mem[rd_addr];
    en_q <= energy_mem[rd_addr];
    mn_q <= mean_mem[rd_addr];
    sh_v_q <= sh_valid[rd_addr];
  end

  csnr_div #(.NumW(NumW), .DenW(SumW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csnr_pkg::ST_FILL;
      smooth <= csnr_pkg::SmoothReset;
      sh_valid <= '0;
      pos <= '0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      ph <= '0;
    end else begin
      div_start <= 1'b0;
      if (cfg_valid && cfg_ready) smooth <= cfg_data;
      unique case (state)
        csnr_pkg::ST_FILL: begin
          if (in_valid) begin
            if (restart) begin
              sh_valid <= '0;
              energy_mem[0] <= energy;
              pos <= (CLASSES == 1) ? '0 : IW'(1);
            end else begin
              energy_mem[pos] <= energy;
              pos <= pos + 1'b1;
            end
            if ((restart ? '0 : pos) == IW'(CLASSES - 1)) begin
              pos <= '0;
              state <= csnr_pkg::ST_RANK;
              idx <= '0;
              j <= '0;
              rd_addr <= '0;
              rd_ok <= 1'b0;
              ph <= 2'd0;
            end
          end
        end
        csnr_pkg::ST_RANK: begin
          // sweep j over the store; ph 0 latches the share of idx
          rd_ok <= 1'b1;
          j_q <= rd_addr;
          if (ph == 2'd0) begin
            if (rd_ok) begin
              cur <= sh_rd;
              ph <= 2'd1;
              rank <= '0;
              rd_addr <= '0;
              j <= JW'(1);
              rd_ok <= 1'b0;
            end
          end else begin
            rank <= rank_new;
            if (j < JW'(CLASSES)) begin
              rd_addr <= j[IW-1:0];
              j <= j + 1'b1;
            end else if (rd_ok) begin
              ph <= 2'd2;
            end
            if (ph == 2'd2) begin
              rank_tab[rank_new[IW-1:0]] <= {12'd0, 4'(idx)};
              rd_ok <= 1'b0;
              ph <= 2'd0;
              if (idx == IW'(CLASSES - 1)) begin
                state <= csnr_pkg::ST_EMIT;
                emit_i <= '0;
                ph <= 2'd0;
                rd_addr <= (rank_new == 4'd0) ? idx : rank_tab[0][IW-1:0];
              end else begin
                idx <= idx + 1'b1;
                rd_addr <= idx + 1'b1;
              end
            end
          end
        end
        csnr_pkg::ST_EMIT: begin
          if (out_valid) begin
            if (!out_stall) begin
              out_valid <= 1'b0;
              if (emit_i == IW'(CLASSES - 1)) begin
                state <= csnr_pkg::ST_MEAN;
                idx <= '0;
                rd_addr <= '0;
                sum <= '0;
                ph <= 2'd0;
              end else begin
                emit_i <= emit_i + 1'b1;
                rd_addr <= rank_tab[emit_i + 1'b1][IW-1:0];
                ph <= 2'd0;
              end
            end
          end else if (ph == 2'd0) begin
            ph <= 2'd1;
          end else begin
            out_valid <= 1'b1;
            res_share <= sh_rd;
            res_pc <= 4'(rank_tab[emit_i]);
            res_last <= (emit_i == IW'(CLASSES - 1));
          end
        end
        csnr_pkg::ST_MEAN: begin
          if (ph == 2'd0) begin
            ph <= 2'd1;
          end else if (ph == 2'd1) begin
            div_num <= NumW'(sh_rd) * NumW'(n - 7'd1) + NumW'(en_q) + NumW'(n >> 1);
            div_den <= SumW'(n);
            div_start <= 1'b1;
            ph <= 2'd2;
          end else if (div_done) begin
            mean_mem[idx] <= div_quo[15:0];
            sum <= sum + SumW'(div_quo[15:0]);
            ph <= 2'd0;
            if (idx == IW'(CLASSES - 1)) begin
              state <= csnr_pkg::ST_DIVIDE;
              idx <= '0;
              rd_addr <= '0;
            end else begin
              idx <= idx + 1'b1;
              rd_addr <= idx + 1'b1;
            end
          end
        end
        csnr_pkg::ST_DIVIDE: begin
          if (sum == '0) begin
            sh_valid <= '0;
            state <= csnr_pkg::ST_FILL;
          end else if (ph == 2'd0) begin
            ph <= 2'd1;
          end else if (ph == 2'd1) begin
            div_num <= NumW'(mn_q) * NumW'(csnr_pkg::ShareOne) + NumW'(sum >> 1);
            div_den <= sum;
            div_start <= 1'b1;
            ph <= 2'd2;
          end else if (div_done) begin
            share_mem[idx] <= (div_quo > NumW'(csnr_pkg::ShareOne))
                              ? csnr_pkg::ShareOne : div_quo[15:0];
            sh_valid[idx] <= 1'b1;
            ph <= 2'd0;
            if (idx == IW'(CLASSES - 1)) begin
              state <= csnr_pkg::ST_FILL;
            end else begin
              idx <= idx + 1'b1;
              rd_addr <= idx + 1'b1;
            end
          end
        end
        default: state <= csnr_pkg::ST_FILL;
      endcase
    end
  end
endmodule

/* tb/chroma_smooth_normalize_rank_checker.sv */
// Checker for the chroma share smoother: predicts ranked shares per frame and compares beats.
// Depends on csnr_pkg; watches the input, output and configuration channels of the core.
`timescale 1ns / 1ps
module chroma_smooth_normalize_rank_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] energy,
  input  logic        restart,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  pitch_class,
  input  logic [15:0] share,
  input  logic        last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  output int          fail_count,
  output int          pending
);
  localparam int NCls = 12;

  typedef struct packed {
    logic [csnr_pkg::PcW-1:0]    pc;
    logic [csnr_pkg::ShareW-1:0] sh;
    logic                        lst;
  } ranked_t;

  logic [csnr_pkg::ShareW-1:0] shares [NCls];
  logic [15:0]                 frame_e [NCls];
  int unsigned                 pos;
  logic [csnr_pkg::CfgW-1:0]   smooth_n;
  ranked_t                     ranked_q [$];

  function automatic logic [csnr_pkg::ShareW-1:0] one_twelfth();
    return csnr_pkg::ShareW'(32'(csnr_pkg::ShareOne) / NCls);
  endfunction

  task automatic push_ranking();
    int unsigned rank;
    ranked_t r;
    ranked_t row [NCls];
    for (int i = 0; i < NCls; i++) begin
      rank = 0;
      for (int j = 0; j < NCls; j++)
        if (shares[j] > shares[i] || (shares[j] == shares[i] && j < i)) rank++;
      r.pc = csnr_pkg::PcW'(i);
      r.sh = shares[i];
      r.lst = (rank == NCls - 1);
      row[rank] = r;
    end
    for (int k = 0; k < NCls; k++) ranked_q.push_back(row[k]);
  endtask

  task automatic smooth_and_normalize();
    longint unsigned n, total, v;
    longint unsigned mean [NCls];
    n = smooth_n;
    total = 0;
    if (n < 1) n = 1;
    if (n > 64) n = 64;
    for (int i = 0; i < NCls; i++) begin
      mean[i] = (longint'(shares[i]) * (n - 1) + frame_e[i] + n / 2) / n;
      total += mean[i];
    end
    for (int i = 0; i < NCls; i++) begin
      if (total == 0) shares[i] = one_twelfth();
      else begin
        v = (mean[i] * 65535 + total / 2) / total;
        if (v > 65535) v = 65535;
        shares[i] = csnr_pkg::ShareW'(v);
      end
    end
  endtask

  always @(posedge clk) begin
    ranked_t exp_r;
    if (rst) begin
      for (int i = 0; i < NCls; i++) shares[i] = one_twelfth();
      pos = 0;
      smooth_n = csnr_pkg::SmoothReset;
      ranked_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) smooth_n = cfg_data;
      if (out_valid && !out_stall) begin
        if (ranked_q.size() == 0) begin
          $error("unexpected result beat pitch_class=%0d share=%0d", pitch_class, share);
          fail_count++;
        end else begin
          exp_r = ranked_q.pop_front();
          if (pitch_class !== exp_r.pc) begin
            $error("pitch_class expected %0d actual %0d", exp_r.pc, pitch_class);
            fail_count++;
          end
          if (share !== exp_r.sh) begin
            $error("share expected %0d actual %0d", exp_r.sh, share);
            fail_count++;
          end
          if (last !== exp_r.lst) begin
            $error("last expected %0d actual %0d", exp_r.lst, last);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (restart) begin
          for (int i = 0; i < NCls; i++) shares[i] = one_twelfth();
          pos = 0;
        end
        if (pos >= NCls) pos = 0;
        frame_e[pos] = energy;
        pos++;
        if (pos == NCls) begin
          push_ranking();
          smooth_and_normalize();
          pos = 0;
        end
      end
    end
    pending = ranked_q.size();
  end
endmodule

/* tb/chroma_smooth_normalize_rank_core_tb.sv */
// Testbench top for the chroma share smoother: drives energy, restart and configuration beats.
// Depends on csnr_pkg, the core and chroma_smooth_normalize_rank_checker.
`timescale 1ns / 1ps
module chroma_smooth_normalize_rank_core_tb;
  localparam int CycleLimit = 1500000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] energy = '0;
  logic        restart = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  pitch_class;
  logic [15:0] share;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;
  int          fail_count;
  int          pending;
  int          cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  chroma_smooth_normalize_rank_core u_top (.*);
  chroma_smooth_normalize_rank_checker u_chk (.*);

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stalls: calm stretches alternate with bursty ones
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!rst && (cycles / 3000) % 3 != 0 && $urandom_range(0, 3) == 0) begin
      stall_left <= gap_len();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // hold valid after an accepted beat; the next call replaces or drops it, an idle step drops it
  task automatic send_beat(input logic [15:0] e, input logic rs);
    int g;
    g = (cycles / 5000) % 4 == 0 ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    energy <= e;
    restart <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_smoothing(input logic [6:0] n);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input int style);
    logic [15:0] e;
    for (int i = 0; i < 12; i++) begin
      case (style)
        0: e = 16'd0;
        1: e = 16'hFFFF;
        2: e = (i % 3 == 0) ? 16'hFFFF : 16'd0;
        default: e = 16'($urandom);
      endcase
      send_beat(e, 1'b0);
    end
  endtask

  initial begin
    logic [6:0] n_set [5];
    n_set = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd5};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_frame(0);
    send_frame(1);
    send_beat(16'h1234, 1'b0);
    send_beat(16'hABCD, 1'b1);
    send_frame(2);
    for (int p = 0; p < 5; p++) begin
      write_smoothing(n_set[p]);
      for (int f = 0; f < 7; f++) begin
        if ($urandom_range(0, 9) == 0)
          for (int k = $urandom_range(1, 11); k > 0; k--)
            send_beat(16'($urandom), 1'b0);
        if ($urandom_range(0, 9) == 0) send_beat(16'($urandom), 1'b1);
        send_frame($urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : 3);
      end
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

/* sim.f */
rtl/core/csnr_pkg.sv
rtl/core/csnr_div.sv
rtl/core/chroma_smooth_normalize_rank_core.sv
tb/chroma_smooth_normalize_rank_checker.sv
tb/chroma_smooth_normalize_rank_core_tb.sv
